### sv/ulr_pkg.sv
package ulr_pkg;

  localparam int unsigned BufferDepth = 128;
  localparam int unsigned SlotW       = $clog2(BufferDepth);
  localparam int unsigned CountW      = $clog2(BufferDepth + 1);
  localparam int unsigned PeriodW     = 16;
  localparam int unsigned CountdownW  = PeriodW + 1;
  localparam int unsigned BitsLeftW   = 4;
  localparam int unsigned DataW       = 8;

  localparam logic [PeriodW-1:0]   BitPeriodReset = PeriodW'(1000000 / 9600);
  localparam logic [DataW-1:0]     NewlineCode    = DataW'(10);
  localparam logic [BitsLeftW-1:0] BitsPerFrame   = BitsLeftW'(DataW);
  localparam logic [CountW-1:0]    CountFull      = CountW'(BufferDepth);
  localparam logic [SlotW-1:0]     SlotLast       = SlotW'(BufferDepth - 1);

  typedef struct packed {
    logic [DataW-1:0]  rx_byte;
    logic [SlotW-1:0]  slot;
    logic              line_end;
    logic [CountW-1:0] line_length;
    logic              overflow;
  } ulr_result_t;

endpackage

### sv/ulr_core.sv
module ulr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          rxd_i,
  input  logic [ulr_pkg::PeriodW-1:0]   bit_period_i,
  output logic                          res_valid_o,
  output ulr_pkg::ulr_result_t          res_o
);
  import ulr_pkg::*;

  logic                  prev_level_q, prev_level_d;
  logic                  receiving_q, receiving_d;
  logic [CountdownW-1:0] countdown_q, countdown_d;
  logic [BitsLeftW-1:0]  bits_left_q, bits_left_d;
  logic [DataW-1:0]      shift_q, shift_d;
  logic [CountW-1:0]     char_count_q, char_count_d;
  logic                  full, is_nl;

  always_comb begin
    prev_level_d = rxd_i;
    receiving_d  = receiving_q;
    countdown_d  = countdown_q;
    bits_left_d  = bits_left_q;
    shift_d      = shift_q;
    char_count_d = char_count_q;
    res_valid_o  = 1'b0;
    full         = (char_count_q >= CountFull);
    is_nl        = 1'b0;
    res_o        = '0;
    if (!receiving_q) begin
      if (prev_level_q && !rxd_i) begin
        receiving_d = 1'b1;
        countdown_d = {1'b0, bit_period_i} + {2'b00, bit_period_i[PeriodW-1:1]};
        bits_left_d = BitsPerFrame;
      end
    end else if (countdown_q > CountdownW'(1)) begin
      countdown_d = countdown_q - CountdownW'(1);
    end else begin
      shift_d     = {rxd_i, shift_q[DataW-1:1]};
      countdown_d = {1'b0, bit_period_i};
      bits_left_d = bits_left_q - BitsLeftW'(1);
      if (bits_left_q == BitsLeftW'(1)) begin
        is_nl             = (shift_d == NewlineCode);
        res_valid_o       = 1'b1;
        res_o.rx_byte     = shift_d;
        res_o.slot        = full ? SlotLast : char_count_q[SlotW-1:0];
        res_o.line_end    = is_nl;
        res_o.line_length = is_nl ? char_count_q : '0;
        res_o.overflow    = full;
        if (is_nl) begin
          char_count_d = '0;
        end else if (!full) begin
          char_count_d = char_count_q + CountW'(1);
        end
        receiving_d = 1'b0;
        bits_left_d = BitsPerFrame;
        countdown_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      receiving_q  <= 1'b0;
      countdown_q  <= '0;
      bits_left_q  <= BitsPerFrame;
      shift_q      <= '0;
      char_count_q <= '0;
    end else if (step_i) begin
      prev_level_q <= prev_level_d;
      receiving_q  <= receiving_d;
      countdown_q  <= countdown_d;
      bits_left_q  <= bits_left_d;
      shift_q      <= shift_d;
      char_count_q <= char_count_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_count_q <= CountFull)
    else $error("char count past buffer depth");

  a_bits_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q != '0 && bits_left_q <= BitsPerFrame)
    else $error("bits_left out of range");

  a_idle_rearmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !receiving_q |-> (bits_left_q == BitsPerFrame))
    else $error("idle with partial frame");

  a_result_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o) |-> receiving_q && countdown_q <= CountdownW'(1))
    else $error("result outside sample point");

  a_frame_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o) |=> !receiving_q)
    else $error("frame not closed after last bit");

endmodule

### sv/uart_line_receiver_top.sv
// UART 8N1 line receiver. One rxd sample is taken per item, one item per
// clock when the output side keeps up; a byte waiting unaccepted on the output
// holds the input. An item passes an input register and the frame logic, and
// a byte item is loaded into the output register when the sample item that
// completes it steps through the frame logic. Sampling is timed in items:
// the first data bit 1.5 bit periods after the start edge, then every
// bit_period items; the stop bit is not checked. Each byte carries its slot
// in the current line (saturating at the last slot with overflow set); a
// newline ends the line and reports its length. Write bit_period only while
// no sample item is in flight; it applies from the next bit-timer reload.
module uart_line_receiver_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ulr_pkg::PeriodW-1:0] cfg_bit_period_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        rxd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ulr_pkg::DataW-1:0]   rx_byte_o,
  output logic [ulr_pkg::SlotW-1:0]   slot_o,
  output logic                        line_end_o,
  output logic [ulr_pkg::CountW-1:0]  line_length_o,
  output logic                        overflow_o
);
  import ulr_pkg::*;

  logic [PeriodW-1:0] bit_period_q;
  logic               s1_valid_q;
  logic               s1_rxd_q;
  logic               s1_step;
  logic               out_valid_q;
  ulr_result_t        out_q;
  logic               res_valid;
  ulr_result_t        res;

  assign cfg_ready_o = 1'b1;
  assign s1_step     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BitPeriodReset;
    end else if (cfg_valid_i) begin
      bit_period_q <= cfg_bit_period_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rxd_q <= rxd_i;
    end
  end

  ulr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_step),
    .rxd_i        (s1_rxd_q),
    .bit_period_i (bit_period_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rx_byte_o     = out_q.rx_byte;
  assign slot_o        = out_q.slot;
  assign line_end_o    = out_q.line_end;
  assign line_length_o = out_q.line_length;
  assign overflow_o    = out_q.overflow;

endmodule
